FILE: src/mct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types, constants and byte classification for the Markdown
// character tokenizer.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int POSITION_BITS = 16;
	localparam int FIELD_W       = 16;
	localparam int MAX_RESULTS   = 3;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_DATA_W     = 8;
	localparam int OUT_DATA_W    = 56;

	localparam logic [7:0] CHR_TAB       = 8'h09;
	localparam logic [7:0] CHR_LF        = 8'h0A;
	localparam logic [7:0] CHR_CR        = 8'h0D;
	localparam logic [7:0] CHR_SPACE     = 8'h20;
	localparam logic [7:0] CHR_BANG      = 8'h21;
	localparam logic [7:0] CHR_HASH      = 8'h23;
	localparam logic [7:0] CHR_LPAREN    = 8'h28;
	localparam logic [7:0] CHR_RPAREN    = 8'h29;
	localparam logic [7:0] CHR_STAR      = 8'h2A;
	localparam logic [7:0] CHR_HYPHEN    = 8'h2D;
	localparam logic [7:0] CHR_GREATER   = 8'h3E;
	localparam logic [7:0] CHR_LBRACKET  = 8'h5B;
	localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHR_RBRACKET  = 8'h5D;
	localparam logic [7:0] CHR_BACKTICK  = 8'h60;

	localparam logic [FIELD_W-1:0] LINE_MAX  = 16'hFFFF;
	localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;

	typedef enum logic [4:0] {
		KIND_START         = 5'd0,
		KIND_END           = 5'd1,
		KIND_TEXT          = 5'd2,
		KIND_SPACE         = 5'd3,
		KIND_NEWLINE       = 5'd4,
		KIND_TAB           = 5'd5,
		KIND_HASH          = 5'd6,
		KIND_BANG          = 5'd7,
		KIND_HYPHEN        = 5'd8,
		KIND_BACKTICK      = 5'd9,
		KIND_STAR          = 5'd10,
		KIND_GREATER       = 5'd11,
		KIND_BACKSLASH     = 5'd12,
		KIND_PAREN_OPEN    = 5'd13,
		KIND_PAREN_CLOSE   = 5'd14,
		KIND_BRACKET_OPEN  = 5'd15,
		KIND_BRACKET_CLOSE = 5'd16
	} kind_t;

	typedef logic [POSITION_BITS-1:0] pos_t;

	typedef struct packed {
		logic               last;
		logic [FIELD_W-1:0] line;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] offset;
		kind_t              kind;
	} token_t;

	typedef struct packed {
		logic [1:0]  count;
		token_t [MAX_RESULTS-1:0] tok;
	} bundle_t;

	function automatic logic is_single(input logic [7:0] c);
		case (c)
			CHR_SPACE, CHR_LF, CHR_TAB, CHR_HASH, CHR_BANG, CHR_HYPHEN,
			CHR_BACKTICK, CHR_STAR, CHR_GREATER, CHR_BACKSLASH,
			CHR_LPAREN, CHR_RPAREN, CHR_LBRACKET, CHR_RBRACKET: is_single = 1'b1;
			default: is_single = 1'b0;
		endcase
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		case (c)
			CHR_SPACE:     single_kind = KIND_SPACE;
			CHR_LF:        single_kind = KIND_NEWLINE;
			CHR_TAB:       single_kind = KIND_TAB;
			CHR_HASH:      single_kind = KIND_HASH;
			CHR_BANG:      single_kind = KIND_BANG;
			CHR_HYPHEN:    single_kind = KIND_HYPHEN;
			CHR_BACKTICK:  single_kind = KIND_BACKTICK;
			CHR_STAR:      single_kind = KIND_STAR;
			CHR_GREATER:   single_kind = KIND_GREATER;
			CHR_BACKSLASH: single_kind = KIND_BACKSLASH;
			CHR_LPAREN:    single_kind = KIND_PAREN_OPEN;
			CHR_RPAREN:    single_kind = KIND_PAREN_CLOSE;
			CHR_LBRACKET:  single_kind = KIND_BRACKET_OPEN;
			CHR_RBRACKET:  single_kind = KIND_BRACKET_CLOSE;
			default:       single_kind = KIND_START;
		endcase
	endfunction

	function automatic logic is_stop(input logic [7:0] c);
		is_stop = (c == CHR_CR) || (is_single(c) && c != CHR_SPACE && c != CHR_TAB);
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_field(input pos_t v);
		logic [32:0] ext;
		ext = 33'(v);
		clamp_field = (ext > 33'(FIELD_MAX)) ? FIELD_MAX : ext[FIELD_W-1:0];
	endfunction

endpackage

FILE: src/markdown_char_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markdown_char_tokenizer_core
// Markdown character tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// The slave channel carries one beat per source byte in s_tdata, with
// s_tuser high for an end-of-document beat. The master channel carries one
// token per beat; m_tlast marks the final token caused by an input beat.
// A beat is registered at acceptance and turned into zero to three tokens
// once the queue has room; they land in a four-entry result queue. The
// first token of a beat passes the input register and then the queue
// before it shows on m_tvalid and can meet a master handshake.
// One input beat is taken every cycle while the queue holds at most one
// token, so a stream of bytes that each yield at most one token runs at
// one byte per cycle. Bytes that yield more tokens are bounded by the
// master side, which moves one token per cycle.
// When the receiver stalls, tokens wait in the queue and the input register;
// s_tready is low while that register is full and the queue holds two or more.
// Reset clears the queue and the document state: the next beat begins a
// new document with its start token, at offset zero on line one.
// ----------------------------------------------------------------------------
module markdown_char_tokenizer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mct_pkg::IN_DATA_W-1:0]     s_tdata,  // char_code[7:0]
	input  logic                              s_tuser,  // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mct_pkg::OUT_DATA_W-1:0]    m_tdata,  // token_kind[4:0], text_offset[20:5],
	                                                    // text_length[36:21], line_number[52:37]
	output logic                              m_tlast   // last_of_run
);

	mct_pkg::bundle_t bundle;
	mct_pkg::token_t  tok;
	logic             room;

	mct_tokenizer u_tokenizer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_char   (s_tdata),
		.room      (room),
		.bundle    (bundle)
	);

	mct_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (tok)
	);

	assign m_tdata = {3'b000, tok.line, tok.length, tok.offset, tok.kind};
	assign m_tlast = tok.last;

endmodule

FILE: src/mct_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_tokenizer
// Input register, document state and token generation for one beat.
// ----------------------------------------------------------------------------
module mct_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_action,
	input  logic [7:0]          in_char,
	input  logic                room,
	output mct_pkg::bundle_t    bundle
);

	logic               valid_s1;
	logic               action_s1;
	logic [7:0]         char_s1;
	logic               go;

	logic               started_q;
	logic               in_text_q;
	mct_pkg::pos_t      run_start_q;
	mct_pkg::pos_t      byte_pos_q;
	logic [mct_pkg::FIELD_W-1:0] line_q;

	logic               has_start;
	logic               has_text;
	logic               has_main;
	logic               open_run;
	logic               text_after;
	logic               single;
	mct_pkg::kind_t     skind;
	mct_pkg::token_t    t_start;
	mct_pkg::token_t    t_text;
	mct_pkg::token_t    t_main;
	mct_pkg::pos_t      pos_next;
	logic [1:0]         n;

	assign in_ready = !valid_s1 || room;
	assign go       = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= in_action;
			char_s1   <= in_char;
		end
	end

	always_comb begin
		skind      = mct_pkg::single_kind(char_s1);
		single     = mct_pkg::is_single(char_s1);
		has_start  = !started_q;
		if (action_s1) begin
			has_text   = in_text_q;
			text_after = 1'b0;
			has_main   = 1'b1;
			open_run   = 1'b0;
		end else begin
			has_text   = in_text_q && mct_pkg::is_stop(char_s1);
			text_after = in_text_q && !mct_pkg::is_stop(char_s1);
			has_main   = !text_after && char_s1 != mct_pkg::CHR_CR && single;
			open_run   = !text_after && char_s1 != mct_pkg::CHR_CR && !single;
		end
		pos_next = (byte_pos_q == '1) ? byte_pos_q : byte_pos_q + 1'b1;

		t_start.kind   = mct_pkg::KIND_START;
		t_start.offset = '0;
		t_start.length = '0;
		t_start.line   = line_q;
		t_start.last   = !has_text && !has_main;

		t_text.kind    = mct_pkg::KIND_TEXT;
		t_text.offset  = mct_pkg::clamp_field(run_start_q);
		t_text.length  = mct_pkg::clamp_field(byte_pos_q - run_start_q);
		t_text.line    = line_q;
		t_text.last    = !has_main;

		t_main.kind    = action_s1 ? mct_pkg::KIND_END : skind;
		t_main.offset  = mct_pkg::clamp_field(byte_pos_q);
		t_main.length  = action_s1 ? '0 : mct_pkg::FIELD_W'(1);
		t_main.line    = line_q;
		t_main.last    = 1'b1;

		bundle = '0;
		n = 2'd0;
		if (has_start) begin
			bundle.tok[n] = t_start;
			n = n + 2'd1;
		end
		if (has_text) begin
			bundle.tok[n] = t_text;
			n = n + 2'd1;
		end
		if (has_main) begin
			bundle.tok[n] = t_main;
			n = n + 2'd1;
		end
		bundle.count = go ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			in_text_q   <= 1'b0;
			run_start_q <= '0;
			byte_pos_q  <= '0;
			line_q      <= mct_pkg::FIELD_W'(1);
		end else if (go) begin
			if (action_s1) begin
				started_q   <= 1'b0;
				in_text_q   <= 1'b0;
				run_start_q <= '0;
				byte_pos_q  <= '0;
				line_q      <= mct_pkg::FIELD_W'(1);
			end else begin
				started_q  <= 1'b1;
				in_text_q  <= text_after || open_run;
				byte_pos_q <= pos_next;
				if (open_run) begin
					run_start_q <= byte_pos_q;
				end
				if (has_main && skind == mct_pkg::KIND_NEWLINE && line_q != mct_pkg::LINE_MAX) begin
					line_q <= line_q + 1'b1;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count reached zero");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_text_q |-> run_start_q <= byte_pos_q)
		else $error("open run starts beyond the byte position");
`endif

endmodule

FILE: src/mct_token_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_token_fifo
// Result queue that takes up to three tokens a cycle and sends one beat a
// cycle while out_ready is high.
// ----------------------------------------------------------------------------
module mct_token_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  mct_pkg::bundle_t bundle,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output mct_pkg::token_t  out_tok
);

	localparam logic [mct_pkg::QUEUE_CW-1:0] ROOM_LIMIT =
		mct_pkg::QUEUE_CW'(mct_pkg::QUEUE_DEPTH - mct_pkg::MAX_RESULTS);
	localparam logic [mct_pkg::QUEUE_CW-1:0] DEPTH_C =
		mct_pkg::QUEUE_CW'(mct_pkg::QUEUE_DEPTH);

	mct_pkg::token_t mem_q [mct_pkg::QUEUE_DEPTH];
	logic [mct_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [mct_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [mct_pkg::QUEUE_CW-1:0] count_q;
	logic pop;

	assign out_valid = count_q != '0;
	assign room      = count_q <= ROOM_LIMIT;
	assign pop       = out_valid && out_ready;
	assign out_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < mct_pkg::MAX_RESULTS; i++) begin
			if (2'(i) < bundle.count) begin
				mem_q[wr_ptr_q + mct_pkg::QUEUE_AW'(i)] <= bundle.tok[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + mct_pkg::QUEUE_AW'(bundle.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + mct_pkg::QUEUE_CW'(bundle.count)
				- mct_pkg::QUEUE_CW'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("token queue overflow");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.count != 2'd0 |-> room)
		else $error("tokens pushed without room");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.count != 2'd0 |=> out_valid)
		else $error("pushed tokens not visible");
`endif

endmodule
